@@ rtl/core/cov_pkg.sv @@
package cov_pkg;

   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = 65;
   localparam int LATENCY    = 3 + SQRT_STEPS + DIV_STEPS + SQRT_STEPS + 4;
   localparam int CSR_AW     = 5;

   localparam logic [2:0] REG_CENTER_X       = 3'd0;
   localparam logic [2:0] REG_CENTER_Y       = 3'd1;
   localparam logic [2:0] REG_CENTER_Z       = 3'd2;
   localparam logic [2:0] REG_CENTER_MASS    = 3'd3;
   localparam logic [2:0] REG_VELOCITY_SCALE = 3'd4;

   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   // one step of a floor square root, two radicand bits per step
   typedef struct packed {
      logic [65:0] rad;
      logic [34:0] rem;
      logic [32:0] root;
   } sqrt_type;

   // one step of a restoring division, one quotient bit per step
   typedef struct packed {
      logic [64:0] num;
      logic [32:0] rem;
      logic [32:0] den;
      logic [64:0] quo;
   } div_type;

   typedef struct packed {
      logic [32:0] ax;
      logic [32:0] az;
      logic        neg_x;
      logic        neg_z;
   } front_type;

   typedef struct packed {
      logic neg_x;
      logic neg_z;
      logic zero;
   } mid_type;

   typedef struct packed {
      logic [32:0] ux;
      logic [32:0] uz;
      logic        neg_x;
      logic        neg_z;
      logic        zero;
   } back_type;

endpackage

@@ rtl/core/cov_if.sv @@
interface cov_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface cov_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_z;
   logic               saturated;
   modport source (output valid, output vel_x, output vel_z, output saturated, input ready);
   modport sink (input valid, input vel_x, input vel_z, input saturated, output ready);
endinterface

@@ rtl/core/circular_orbit_velocity.sv @@
// Throughput: one transaction per cycle while responses are taken; the
// pipeline is a chain of square-root and division cells, one bit per cell,
// all advancing together.
// A held response freezes the whole chain until it is taken.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults: center 0, mass 1.0, scale 1.0.
module circular_orbit_velocity import cov_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   cov_req_if.sink           req,
   cov_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [31:0] center_mass_ff, velocity_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff       <= '0;
         center_y_ff       <= '0;
         center_z_ff       <= '0;
         center_mass_ff    <= Q_ONE;
         velocity_scale_ff <= Q_ONE;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_CENTER_X:       center_x_ff       <= pwdata;
            REG_CENTER_Y:       center_y_ff       <= pwdata;
            REG_CENTER_Z:       center_z_ff       <= pwdata;
            REG_CENTER_MASS:    center_mass_ff    <= pwdata;
            REG_VELOCITY_SCALE: velocity_scale_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CENTER_X:       prdata = center_x_ff;
         REG_CENTER_Y:       prdata = center_y_ff;
         REG_CENTER_Z:       prdata = center_z_ff;
         REG_CENTER_MASS:    prdata = center_mass_ff;
         REG_VELOCITY_SCALE: prdata = velocity_scale_ff;
         default:            prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // pipeline control
   logic               en;
   logic [LATENCY-1:0] vld_ff;

   assign en        = !vld_ff[LATENCY-1] || rsp.ready;
   assign req.ready = en;
   assign rsp.valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req.valid};
      end
   end

   // stage 0: offsets from the center, magnitudes
   logic signed [32:0] dx, dy, dz;
   logic [32:0]        ay_ff;
   front_type          side0_ff;

   assign dx = {req.pos_x[31], req.pos_x} - {center_x_ff[31], center_x_ff};
   assign dy = {req.pos_y[31], req.pos_y} - {center_y_ff[31], center_y_ff};
   assign dz = {req.pos_z[31], req.pos_z} - {center_z_ff[31], center_z_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff.ax    <= dx[32] ? 33'(-dx) : 33'(dx);
         ay_ff          <= dy[32] ? 33'(-dy) : 33'(dy);
         side0_ff.az    <= dz[32] ? 33'(-dz) : 33'(dz);
         side0_ff.neg_x <= !dz[32] && (dz != '0);
         side0_ff.neg_z <= dx[32];
      end
   end

   // stage 1: squares
   logic [65:0] sx_ff, sy_ff, sz_ff;
   front_type   side1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff    <= 66'(side0_ff.ax) * 66'(side0_ff.ax);
         sy_ff    <= 66'(ay_ff) * 66'(ay_ff);
         sz_ff    <= 66'(side0_ff.az) * 66'(side0_ff.az);
         side1_ff <= side0_ff;
      end
   end

   // stage 2: horizontal and full squared distance
   logic [65:0] hsq_ff, dsq_ff;
   front_type   side2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hsq_ff   <= sx_ff + sz_ff;
         dsq_ff   <= sx_ff + sy_ff + sz_ff;
         side2_ff <= side1_ff;
      end
   end

   // distance and horizontal radius
   sqrt_type  d_chain [0:SQRT_STEPS];
   sqrt_type  h_chain [0:SQRT_STEPS];
   front_type side_a_ff [0:SQRT_STEPS-1];

   assign d_chain[0] = '{rad: dsq_ff, rem: '0, root: '0};
   assign h_chain[0] = '{rad: hsq_ff, rem: '0, root: '0};

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_a
      cov_sqrt_cell u_d (.clock(clock), .enable(en), .src(d_chain[i]), .dst(d_chain[i+1]));
      cov_sqrt_cell u_h (.clock(clock), .enable(en), .src(h_chain[i]), .dst(h_chain[i+1]));
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               side_a_ff[i] <= side2_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               side_a_ff[i] <= side_a_ff[i-1];
            end
         end
      end
   end

   // mass over distance and the unit perpendicular
   logic [32:0] d_root, h_root;
   front_type   side_a_last;
   div_type     q_chain [0:DIV_STEPS];
   div_type     x_chain [0:DIV_STEPS];
   div_type     z_chain [0:DIV_STEPS];
   mid_type     side_b_ff [0:DIV_STEPS-1];
   mid_type     side_b_first;

   assign d_root      = d_chain[SQRT_STEPS].root;
   assign h_root      = h_chain[SQRT_STEPS].root;
   assign side_a_last = side_a_ff[SQRT_STEPS-1];

   assign q_chain[0] = '{num: {1'b0, center_mass_ff, 32'b0}, rem: '0, den: d_root, quo: '0};
   assign x_chain[0] = '{num: {side_a_last.az, 32'b0}, rem: '0, den: h_root, quo: '0};
   assign z_chain[0] = '{num: {side_a_last.ax, 32'b0}, rem: '0, den: h_root, quo: '0};

   assign side_b_first = '{neg_x: side_a_last.neg_x, neg_z: side_a_last.neg_z,
                           zero: (d_root == '0) || (h_root == '0)};

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cov_div_cell u_q (.clock(clock), .enable(en), .src(q_chain[i]), .dst(q_chain[i+1]));
      cov_div_cell u_x (.clock(clock), .enable(en), .src(x_chain[i]), .dst(x_chain[i+1]));
      cov_div_cell u_z (.clock(clock), .enable(en), .src(z_chain[i]), .dst(z_chain[i+1]));
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               side_b_ff[i] <= side_b_first;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               side_b_ff[i] <= side_b_ff[i-1];
            end
         end
      end
   end

   // root of mass over distance
   sqrt_type r_chain [0:SQRT_STEPS];
   back_type side_c_ff [0:SQRT_STEPS-1];
   back_type side_c_first;
   mid_type  side_b_last;

   assign side_b_last = side_b_ff[DIV_STEPS-1];
   assign r_chain[0]  = '{rad: {2'b00, q_chain[DIV_STEPS].quo[63:0]}, rem: '0, root: '0};
   assign side_c_first = '{ux: x_chain[DIV_STEPS].quo[32:0], uz: z_chain[DIV_STEPS].quo[32:0],
                           neg_x: side_b_last.neg_x, neg_z: side_b_last.neg_z,
                           zero: side_b_last.zero};

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_b
      cov_sqrt_cell u_r (.clock(clock), .enable(en), .src(r_chain[i]), .dst(r_chain[i+1]));
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               side_c_ff[i] <= side_c_first;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               side_c_ff[i] <= side_c_ff[i-1];
            end
         end
      end
   end

   // speed, then speed times unit vector in split partial products
   logic [63:0] prod_ff;
   logic [47:0] sp;
   logic [64:0] plx_ff, plz_ff;
   logic [48:0] phx_ff, phz_ff;
   logic [48:0] mx_ff, mz_ff;
   back_type    side_m1_ff, side_m2_ff, side_m3_ff;

   assign sp = prod_ff[63:16];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= 64'(r_chain[SQRT_STEPS].root[31:0]) * 64'(velocity_scale_ff);
         side_m1_ff <= side_c_ff[SQRT_STEPS-1];
         plx_ff     <= 65'(sp[31:0]) * 65'(side_m1_ff.ux);
         plz_ff     <= 65'(sp[31:0]) * 65'(side_m1_ff.uz);
         phx_ff     <= 49'(sp[47:32]) * 49'(side_m1_ff.ux);
         phz_ff     <= 49'(sp[47:32]) * 49'(side_m1_ff.uz);
         side_m2_ff <= side_m1_ff;
         mx_ff      <= phx_ff + 49'(plx_ff[64:32]);
         mz_ff      <= phz_ff + 49'(plz_ff[64:32]);
         side_m3_ff <= side_m2_ff;
      end
   end

   // clamp to signed 32 bits; returns {sat, value}
   function automatic logic [32:0] clamp_out(input logic [48:0] mag, input logic neg);
      logic [31:0] val;
      logic        sat;
      sat = 1'b0;
      if (neg) begin
         if (mag > 49'h0_8000_0000) begin
            sat = 1'b1;
            val = 32'h8000_0000;
         end else begin
            val = 32'(49'd0 - mag);
         end
      end else begin
         if (mag > 49'h0_7FFF_FFFF) begin
            sat = 1'b1;
            val = 32'h7FFF_FFFF;
         end else begin
            val = mag[31:0];
         end
      end
      return {sat, val};
   endfunction

   logic [32:0] cx, cz;
   logic [31:0] vel_x_ff, vel_z_ff;
   logic        sat_ff;

   assign cx = clamp_out(mx_ff, side_m3_ff.neg_x);
   assign cz = clamp_out(mz_ff, side_m3_ff.neg_z);

   always_ff @(posedge clock) begin
      if (en) begin
         if (side_m3_ff.zero) begin
            vel_x_ff <= '0;
            vel_z_ff <= '0;
            sat_ff   <= 1'b0;
         end else begin
            vel_x_ff <= cx[31:0];
            vel_z_ff <= cz[31:0];
            sat_ff   <= cx[32] | cz[32];
         end
      end
   end

   assign rsp.vel_x     = vel_x_ff;
   assign rsp.vel_z     = vel_z_ff;
   assign rsp.saturated = sat_ff;

endmodule

@@ rtl/core/cov_sqrt_cell.sv @@
module cov_sqrt_cell import cov_pkg::*; (
   input  logic     clock,
   input  logic     enable,
   input  sqrt_type src,
   output sqrt_type dst
);

   logic [36:0] trial_rem;
   logic [36:0] trial;
   sqrt_type    step_in;
   sqrt_type    step_ff;

   always_comb begin
      trial_rem   = {src.rem, src.rad[65:64]};
      trial       = {2'b00, src.root, 2'b01};
      step_in.rad = {src.rad[63:0], 2'b00};
      if (trial_rem >= trial) begin
         step_in.rem  = 35'(trial_rem - trial);
         step_in.root = {src.root[31:0], 1'b1};
      end else begin
         step_in.rem  = trial_rem[34:0];
         step_in.root = {src.root[31:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign dst = step_ff;

endmodule

@@ rtl/core/cov_div_cell.sv @@
module cov_div_cell import cov_pkg::*; (
   input  logic    clock,
   input  logic    enable,
   input  div_type src,
   output div_type dst
);

   logic [33:0] trial_rem;
   div_type     step_in;
   div_type     step_ff;

   always_comb begin
      trial_rem   = {src.rem, src.num[64]};
      step_in.num = {src.num[63:0], 1'b0};
      step_in.den = src.den;
      if (trial_rem >= {1'b0, src.den}) begin
         step_in.rem = 33'(trial_rem - {1'b0, src.den});
         step_in.quo = {src.quo[63:0], 1'b1};
      end else begin
         step_in.rem = trial_rem[32:0];
         step_in.quo = {src.quo[63:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign dst = step_ff;

endmodule

@@ rtl/core/cov_checker.sv @@
module cov_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] vel_x,
   input logic [31:0] vel_z,
   input logic        saturated
);

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vel_x) && $stable(vel_z)
         && $stable(saturated))
      else $error("response changed while stalled");

   // a clamped transaction shows a rail value
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> vel_x == 32'h7FFF_FFFF || vel_x == 32'h8000_0000
         || vel_z == 32'h7FFF_FFFF || vel_z == 32'h8000_0000)
      else $error("saturated without rail value");

   // empty output stage never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind circular_orbit_velocity cov_checker u_cov_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .vel_x     (rsp.vel_x),
   .vel_z     (rsp.vel_z),
   .saturated (rsp.saturated)
);
